@@ sv/psev_pkg.sv @@
// ----------------------------------------------------------------------------
// psev_pkg: shared types and constants of the postfix stack evaluator
// Character codes, status and fatal codes, and the stack request type.
// ----------------------------------------------------------------------------
package psev_pkg;

    localparam int WORD_W   = 32;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 3;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_DIV0    = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_UNDER   = 3'd3,
        ST_OVER    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        FATAL_NONE    = 2'd0,
        FATAL_DIV0    = 2'd1,
        FATAL_UNKNOWN = 2'd2
    } t_fatal;

    typedef enum logic [1:0] {
        STK_HOLD = 2'd0,
        STK_PUSH = 2'd1,
        STK_POP  = 2'd2
    } t_stk_op;

    typedef struct packed {
        t_stk_op           op;
        logic [WORD_W-1:0] data;
    } t_stk_req;

endpackage

@@ sv/psev_if.sv @@
// ----------------------------------------------------------------------------
// psev_if: request channels of the postfix stack evaluator
// Character channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface psev_in_if import psev_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    modport source(output valid, output char_code, output last_char, input ready);
    modport sink(input valid, input char_code, input last_char, output ready);
endinterface

interface psev_out_if import psev_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [WORD_W-1:0]   value;
    logic        [STATUS_W-1:0] status;

    modport source(output valid, output value, output status, input ready);
    modport sink(input valid, input value, input status, output ready);
endinterface

@@ sv/psev_cell.sv @@
// ----------------------------------------------------------------------------
// psev_cell: one word of the operand stack chain
// Take the word above on push, the word below on pop, hold otherwise.
// ----------------------------------------------------------------------------
module psev_cell import psev_pkg::*; (
    input  logic              i_clk,
    input  t_stk_op           i_op,
    input  logic [WORD_W-1:0] i_above,
    input  logic [WORD_W-1:0] i_below,
    output logic [WORD_W-1:0] o_word
);

    logic [WORD_W-1:0] r_word;

    always_ff @(posedge i_clk) begin
        case (i_op)
            STK_PUSH: r_word <= i_above;
            STK_POP:  r_word <= i_below;
            default:  r_word <= r_word;
        endcase
    end

    assign o_word = r_word;

endmodule

@@ sv/psev_stack.sv @@
// ----------------------------------------------------------------------------
// psev_stack: operand stack as a row of shifting cells
// Cell 0 is the top; a push shifts down, a pop shifts up.
// ----------------------------------------------------------------------------
module psev_stack import psev_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  t_stk_req          i_req,
    output logic [WORD_W-1:0] o_top
);

    logic [WORD_W-1:0] w_word [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_W-1:0] w_above;
        logic [WORD_W-1:0] w_below;

        if (g == 0) begin : g_first
            assign w_above = i_req.data;
        end else begin : g_mid
            assign w_above = w_word[g-1];
        end

        // the bottom cell has no neighbor below; its word is dead after a pop
        if (g == DEPTH - 1) begin : g_last
            assign w_below = w_word[g];
        end else begin : g_inner
            assign w_below = w_word[g+1];
        end

        psev_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (i_req.op),
            .i_above (w_above),
            .i_below (w_below),
            .o_word  (w_word[g])
        );
    end

    assign o_top = w_word[0];

endmodule

@@ sv/psev_div.sv @@
// ----------------------------------------------------------------------------
// psev_div: unsigned restoring divider
// One quotient bit per cycle; done pulses when the quotient is final.
// ----------------------------------------------------------------------------
module psev_div import psev_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_dividend,
    input  logic [WORD_W-1:0] i_divisor,
    output logic              o_done,
    output logic [WORD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_dvs;
    logic [WORD_W+1:0] w_diff;

    // shifted partial remainder minus divisor; top bit is the borrow
    assign w_diff = {1'b0, r_rem, r_quo[WORD_W-1]} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(WORD_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            if (!w_diff[WORD_W+1]) begin
                r_rem <= w_diff[WORD_W-1:0];
                r_quo <= {r_quo[WORD_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[WORD_W-2:0], r_quo[WORD_W-1]};
                r_quo <= {r_quo[WORD_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ sv/postfix_stack_evaluator.sv @@
// ----------------------------------------------------------------------------
// postfix_stack_evaluator: postfix expression evaluator on an operand stack
// Evaluates one character per request; the last one yields value and status.
// ----------------------------------------------------------------------------
//  channel | port  | direction | payload
//  --------+-------+-----------+------------------------------------------
//  char    | i_in  | in        | char_code[7:0], last_char
//  result  | o_out | out       | value[31:0] signed, status[2:0]
//
//  One character at a time, accepted in idle: a digit or any character after a
//  fatal error runs execute and post; an operator also pops the left operand
//  and operates, pushing unless it errs; / waits on the 32 one-bit divider steps.
//  Reset is synchronous and clears count, flags and control; stack words are
//  never cleared. A result waiting in the output register does not block the
//  next character; only a second last character waits until it is taken.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator import psev_pkg::*; #(
    parameter int STACK_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psev_in_if.sink    i_in,
    psev_out_if.source o_out
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_L,
        S_OP,
        S_DIV,
        S_PUSH,
        S_POST
    } t_state;

    t_state            r_state,  n_state;
    logic [CHAR_W-1:0] r_char,   n_char;
    logic              r_last,   n_last;
    logic [CNT_W-1:0]  r_count,  n_count;
    t_fatal            r_fatal,  n_fatal;
    logic              r_under,  n_under;
    logic              r_over,   n_over;
    logic [WORD_W-1:0] r_rhs,    n_rhs;
    logic [WORD_W-1:0] r_lhs,    n_lhs;
    logic [WORD_W-1:0] r_res,    n_res;
    logic              r_neg,    n_neg;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_value, n_out_value;
    t_status           r_out_status, n_out_status;

    t_stk_req          w_stk_req;
    logic [WORD_W-1:0] w_top;
    logic              w_empty;
    logic              w_full;
    logic              w_digit;
    logic              w_div_start;
    logic              w_div_done;
    logic [WORD_W-1:0] w_quotient;
    logic [WORD_W-1:0] w_lhs_mag;
    logic [WORD_W-1:0] w_rhs_mag;

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_W'(STACK_DEPTH));
    assign w_digit = (r_char >= CH_ZERO) && (r_char <= CH_NINE);

    // operand magnitudes for the unsigned divider
    assign w_lhs_mag = r_lhs[WORD_W-1] ? (WORD_W'(0) - r_lhs) : r_lhs;
    assign w_rhs_mag = r_rhs[WORD_W-1] ? (WORD_W'(0) - r_rhs) : r_rhs;

    always_comb begin
        n_state      = r_state;
        n_char       = r_char;
        n_last       = r_last;
        n_count      = r_count;
        n_fatal      = r_fatal;
        n_under      = r_under;
        n_over       = r_over;
        n_rhs        = r_rhs;
        n_lhs        = r_lhs;
        n_res        = r_res;
        n_neg        = r_neg;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        w_stk_req    = '{op: STK_HOLD, data: r_res};
        w_div_start  = 1'b0;

        // drop the result once the sink takes it
        n_out_valid = r_out_valid && !o_out.ready;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_char  = i_in.char_code;
                    n_last  = i_in.last_char;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                if (r_fatal != FATAL_NONE) begin
                    // ignore everything after a fatal error
                    n_state = S_POST;
                end else if (w_digit) begin
                    // the low nibble of an ASCII digit is its value
                    if (w_full) begin
                        n_over = 1'b1;
                    end else begin
                        w_stk_req = '{op: STK_PUSH, data: WORD_W'(r_char[3:0])};
                        n_count   = r_count + CNT_W'(1);
                    end
                    n_state = S_POST;
                end else begin
                    // pop the right operand; both pops happen before decode
                    if (w_empty) begin
                        n_rhs   = '1;
                        n_under = 1'b1;
                    end else begin
                        n_rhs        = w_top;
                        w_stk_req.op = STK_POP;
                        n_count      = r_count - CNT_W'(1);
                    end
                    n_state = S_POP_L;
                end
            end

            S_POP_L: begin
                if (w_empty) begin
                    n_lhs   = '1;
                    n_under = 1'b1;
                end else begin
                    n_lhs        = w_top;
                    w_stk_req.op = STK_POP;
                    n_count      = r_count - CNT_W'(1);
                end
                n_state = S_OP;
            end

            S_OP: begin
                unique case (r_char)
                    CH_PLUS: begin
                        n_res   = r_lhs + r_rhs;
                        n_state = S_PUSH;
                    end
                    CH_MINUS: begin
                        n_res   = r_lhs - r_rhs;
                        n_state = S_PUSH;
                    end
                    CH_MUL: begin
                        n_res   = WORD_W'(r_lhs * r_rhs);
                        n_state = S_PUSH;
                    end
                    CH_DIV: begin
                        if (r_rhs == '0) begin
                            n_fatal = FATAL_DIV0;
                            n_state = S_POST;
                        end else begin
                            w_div_start = 1'b1;
                            n_neg       = r_lhs[WORD_W-1] ^ r_rhs[WORD_W-1];
                            n_state     = S_DIV;
                        end
                    end
                    default: begin
                        n_fatal = FATAL_UNKNOWN;
                        n_state = S_POST;
                    end
                endcase
            end

            S_DIV: begin
                // truncate toward zero: negate the magnitude quotient
                if (w_div_done) begin
                    n_res   = r_neg ? (WORD_W'(0) - w_quotient) : w_quotient;
                    n_state = S_PUSH;
                end
            end

            S_PUSH: begin
                if (w_full) begin
                    n_over = 1'b1;
                end else begin
                    w_stk_req = '{op: STK_PUSH, data: r_res};
                    n_count   = r_count + CNT_W'(1);
                end
                n_state = S_POST;
            end

            S_POST: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || o_out.ready) begin
                    // take the top as the final value, report, then clear the evaluator
                    n_out_valid = 1'b1;
                    if (r_fatal != FATAL_NONE) begin
                        n_out_value  = '1;
                        n_out_status = t_status'({1'b0, r_fatal});
                    end else begin
                        n_out_value = w_empty ? '1 : w_top;
                        if (r_under || w_empty) begin
                            n_out_status = ST_UNDER;
                        end else if (r_over) begin
                            n_out_status = ST_OVER;
                        end else begin
                            n_out_status = ST_OK;
                        end
                    end
                    n_count = '0;
                    n_fatal = FATAL_NONE;
                    n_under = 1'b0;
                    n_over  = 1'b0;
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_fatal     <= FATAL_NONE;
            r_under     <= 1'b0;
            r_over      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_fatal     <= n_fatal;
            r_under     <= n_under;
            r_over      <= n_over;
            r_out_valid <= n_out_valid;
        end
        r_char       <= n_char;
        r_last       <= n_last;
        r_rhs        <= n_rhs;
        r_lhs        <= n_lhs;
        r_res        <= n_res;
        r_neg        <= n_neg;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    psev_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk (i_clk),
        .i_req (w_stk_req),
        .o_top (w_top)
    );

    psev_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_lhs_mag),
        .i_divisor  (w_rhs_mag),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.value  = r_out_value;
    assign o_out.status = r_out_status;

endmodule

@@ sv/psev_checker.sv @@
// ----------------------------------------------------------------------------
// psev_checker: port checks of the postfix stack evaluator
// Watches the request channels at the top level's ports.
// ----------------------------------------------------------------------------
module psev_checker import psev_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [WORD_W-1:0]   i_out_value,
    input  logic [STATUS_W-1:0] i_out_status
);

    // hold a stalled result unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_value) && $stable(i_out_status)))
        else $error("stalled result changed");

    // one character in flight: no acceptance in the cycle after one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("character accepted back to back");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status <= ST_OVER))
        else $error("status code out of range");

    // a fatal status always carries the all-ones value
    a_fatal_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_status == ST_DIV0 || i_out_status == ST_UNKNOWN))
            |-> (i_out_value == '1))
        else $error("fatal result value is not minus one");

endmodule

bind postfix_stack_evaluator psev_checker u_psev_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_value  (o_out.value),
    .i_out_status (o_out.status)
);
